// ----- hdl/mesh_packet_dedup_router_defines.svh -----
// Assertion macros used by the checker file of the mesh packet router.
`ifndef MESH_PACKET_DEDUP_ROUTER_DEFINES_SVH
`define MESH_PACKET_DEDUP_ROUTER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define MPDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define MPDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mpdr_pkg.sv -----
`timescale 1ns / 1ps
package mpdr_pkg;

  // Field widths of the packet header and of the result.
  localparam int ADDR_W = 8;
  localparam int SEQ_W  = 16;
  localparam int KIND_W = 3;
  localparam int HOP_W  = 8;
  localparam int CMD_W  = 8;
  localparam int CODE_W = 3;

  // Size of the per-source duplicate filter (1 to 256 entries).
  localparam int NODE_COUNT = 256;
  localparam int SLOT_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Address of this node after reset.
  localparam logic [ADDR_W-1:0] OWN_ADDR_RESET = 8'd3;

  // Depth of the queue between the classifier and the resolver.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE          = 3'd0,
    KIND_COMMAND       = 3'd1,
    KIND_COMMAND_ACK   = 3'd2,
    KIND_DATA          = 3'd3,
    KIND_HANDSHAKE     = 3'd4,
    KIND_HANDSHAKE_ACK = 3'd5,
    KIND_GATEWAY       = 3'd6,
    KIND_OTHER         = 3'd7
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    ROUTE_DROP     = 3'd0,
    ROUTE_ACTION   = 3'd1,
    ROUTE_CMD_FWD  = 3'd2,
    ROUTE_DATA_FWD = 3'd3,
    ROUTE_HAND_RX  = 3'd4
  } route_t;

  typedef enum logic [CODE_W-1:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_OWN        = 3'd1,
    CAUSE_NOT_JOINED = 3'd2,
    CAUSE_STALE      = 3'd3,
    CAUSE_UNHANDLED  = 3'd4
  } cause_t;

  // Classified packet as it travels from the front to the back.
  typedef struct packed {
    logic                own_pkt;
    logic                hs_for_us;
    logic                cmd_for_us;
    kind_t               kind;
    logic [SEQ_W-1:0]    seq;
    slot_t               slot;
    logic [HOP_W-1:0]    hops;
    logic [HOP_W-1:0]    hops_inc;
    logic [CMD_W-1:0]    cmd_id;
  } pkt_rec_t;

  // Source address to filter slot, folded at elaboration.
  localparam int ADDR_SPAN = 1 << ADDR_W;
  typedef slot_t slot_lut_t [ADDR_SPAN];

  function automatic slot_lut_t build_slot_lut();
    slot_lut_t lut;
    for (int i = 0; i < ADDR_SPAN; i++) begin
      lut[i] = slot_t'(i % NODE_COUNT);
    end
    return lut;
  endfunction

  localparam slot_lut_t SLOT_LUT = build_slot_lut();

endpackage

// ----- hdl/mpdr_front.sv -----
`timescale 1ns / 1ps
module mpdr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mpdr_pkg::ADDR_W-1:0]  cfg_wr_data,
  input  logic [mpdr_pkg::ADDR_W-1:0]  source_node,
  input  logic [mpdr_pkg::SEQ_W-1:0]   sequence_req,
  input  logic [mpdr_pkg::KIND_W-1:0]  message_kind,
  input  logic [mpdr_pkg::HOP_W-1:0]   hop_count,
  input  logic [mpdr_pkg::CMD_W-1:0]   command_id,
  input  logic [mpdr_pkg::ADDR_W-1:0]  command_target,
  input  logic [mpdr_pkg::ADDR_W-1:0]  handshake_target,
  output mpdr_pkg::pkt_rec_t           rec
);
  import mpdr_pkg::*;

  logic [ADDR_W-1:0] own_address;

  // Node address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDR_RESET;
    end else if (cfg_wr_en) begin
      own_address <= cfg_wr_data;
    end
  end

  // Address compares, slot lookup and hop increment are done here so that
  // the back end only has the sequence compare and the routing choice.
  always_comb begin
    rec.own_pkt    = (source_node == own_address);
    rec.hs_for_us  = (handshake_target == own_address);
    rec.cmd_for_us = (command_target == own_address);
    rec.kind       = kind_t'(message_kind);
    rec.seq        = sequence_req;
    rec.slot       = SLOT_LUT[source_node];
    rec.hops       = hop_count;
    rec.hops_inc   = hop_count + 1'b1;
    rec.cmd_id     = command_id;
  end

endmodule

// ----- hdl/mpdr_queue.sv -----
`timescale 1ns / 1ps
module mpdr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mpdr_pkg::pkt_rec_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mpdr_pkg::pkt_rec_t pop_item
);
  import mpdr_pkg::*;

  pkt_rec_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/mpdr_back.sv -----
`timescale 1ns / 1ps
module mpdr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  mpdr_pkg::pkt_rec_t           pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mpdr_pkg::CODE_W-1:0]  route,
  output logic [mpdr_pkg::HOP_W-1:0]   hops_out,
  output logic [mpdr_pkg::CODE_W-1:0]  drop_cause,
  output logic                         joined
);
  import mpdr_pkg::*;

  typedef enum logic {
    ST_FETCH,
    ST_RESOLVE
  } state_t;

  state_t            state;
  pkt_rec_t          cur;
  logic [SEQ_W-1:0]  seq_mem [NODE_COUNT];
  logic [SEQ_W-1:0]  rd_seq;
  logic [NODE_COUNT-1:0] seen;
  logic              joined_flag;
  logic [CMD_W-1:0]  newest_command;

  logic              commit;
  route_t            res_route;
  cause_t            res_cause;
  logic [HOP_W-1:0]  res_hops;
  logic              join_set;
  logic              take_seq;
  logic              take_cmd;

  assign pop_ready = (state == ST_FETCH);
  assign commit    = (state == ST_RESOLVE) && (!out_valid || out_ready);

  // Filter, join and routing decision for the packet held in cur.
  always_comb begin
    res_route = ROUTE_DROP;
    res_cause = CAUSE_NONE;
    res_hops  = cur.hops;
    join_set  = 1'b0;
    take_seq  = 1'b0;
    take_cmd  = 1'b0;
    if (cur.own_pkt) begin
      res_cause = CAUSE_OWN;
    end else if (!joined_flag) begin
      if (cur.kind == KIND_HANDSHAKE_ACK && cur.hs_for_us) begin
        join_set = 1'b1;
      end else begin
        res_cause = CAUSE_NOT_JOINED;
      end
    end else if (seen[cur.slot] && !(cur.seq > rd_seq)) begin
      res_cause = CAUSE_STALE;
    end else begin
      take_seq = 1'b1;
      case (cur.kind)
        KIND_COMMAND: begin
          if (newest_command < cur.cmd_id && cur.cmd_for_us) begin
            take_cmd  = 1'b1;
            res_route = ROUTE_ACTION;
          end else begin
            res_route = ROUTE_CMD_FWD;
            res_hops  = cur.hops_inc;
          end
        end
        KIND_COMMAND_ACK: begin
          res_route = ROUTE_CMD_FWD;
          res_hops  = cur.hops_inc;
        end
        KIND_DATA: begin
          res_route = ROUTE_DATA_FWD;
          res_hops  = cur.hops_inc;
        end
        KIND_HANDSHAKE: begin
          if (cur.hs_for_us) begin
            res_route = ROUTE_HAND_RX;
          end else begin
            res_route = ROUTE_DATA_FWD;
            res_hops  = cur.hops_inc;
          end
        end
        default: begin
          res_cause = CAUSE_UNHANDLED;
        end
      endcase
    end
  end

  // Last-sequence memory: read on fetch, written when a packet is taken.
  always_ff @(posedge clk) begin
    if (state == ST_FETCH && pop_valid) begin
      rd_seq <= seq_mem[pop_item.slot];
    end
    if (commit && take_seq) begin
      seq_mem[cur.slot] <= cur.seq;
    end
  end

  // Sequencer, filter state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_FETCH;
      out_valid      <= 1'b0;
      joined_flag    <= 1'b0;
      newest_command <= '0;
      seen           <= '0;
    end else begin
      // A new result takes the register as the old one leaves it.
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_FETCH: begin
          if (pop_valid) begin
            cur   <= pop_item;
            state <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (commit) begin
            route      <= res_route;
            hops_out   <= res_hops;
            drop_cause <= res_cause;
            joined     <= joined_flag || join_set;
            if (join_set) begin
              joined_flag <= 1'b1;
            end
            if (take_seq) begin
              seen[cur.slot] <= 1'b1;
            end
            if (take_cmd) begin
              newest_command <= cur.cmd_id;
            end
            state <= ST_FETCH;
          end
        end
        default: begin
          state <= ST_FETCH;
        end
      endcase
    end
  end

endmodule

// ----- hdl/mesh_packet_dedup_router.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Beat contents
// in        input      in_valid / in_ready   source_node, sequence_req, message_kind,
//                                            hop_count, command_id, command_target,
//                                            handshake_target
// out       output     out_valid / out_ready route, hops_out, drop_cause, joined
// cfg       input      cfg_wr_en             cfg_wr_data (own_address, no wait)
//
// The back end resolves one packet at a time: in its fetch state it reads the
// last-sequence memory, and in its resolve state it decides and writes it back.
// An accepted input beat passes through a queue slot and the back end's cur
// register before the output register. A two-entry queue parts classification
// from resolution, so in_ready stays high under an output stall until two beats
// wait behind it; rst is synchronous and clears the queue, the joined flag, the
// newest command id and all source valid bits.
module mesh_packet_dedup_router (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mpdr_pkg::ADDR_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mpdr_pkg::ADDR_W-1:0]  source_node,
  input  logic [mpdr_pkg::SEQ_W-1:0]   sequence_req,
  input  logic [mpdr_pkg::KIND_W-1:0]  message_kind,
  input  logic [mpdr_pkg::HOP_W-1:0]   hop_count,
  input  logic [mpdr_pkg::CMD_W-1:0]   command_id,
  input  logic [mpdr_pkg::ADDR_W-1:0]  command_target,
  input  logic [mpdr_pkg::ADDR_W-1:0]  handshake_target,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mpdr_pkg::CODE_W-1:0]  route,
  output logic [mpdr_pkg::HOP_W-1:0]   hops_out,
  output logic [mpdr_pkg::CODE_W-1:0]  drop_cause,
  output logic                         joined
);
  import mpdr_pkg::*;

  pkt_rec_t front_rec;
  logic     q_valid;
  logic     q_ready;
  pkt_rec_t q_item;

  // Classifier and address register.
  mpdr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .source_node      (source_node),
    .sequence_req     (sequence_req),
    .message_kind     (message_kind),
    .hop_count        (hop_count),
    .command_id       (command_id),
    .command_target   (command_target),
    .handshake_target (handshake_target),
    .rec              (front_rec)
  );

  // Queue between classifier and resolver.
  mpdr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_rec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Duplicate filter, join tracking and routing.
  mpdr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .route      (route),
    .hops_out   (hops_out),
    .drop_cause (drop_cause),
    .joined     (joined)
  );

endmodule

// ----- hdl/mpdr_checker.sv -----
`timescale 1ns / 1ps
`include "mesh_packet_dedup_router_defines.svh"
module mpdr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mpdr_pkg::CODE_W-1:0]  route,
  input logic [mpdr_pkg::HOP_W-1:0]   hops_out,
  input logic [mpdr_pkg::CODE_W-1:0]  drop_cause,
  input logic                         joined
);
  import mpdr_pkg::*;

  // A result beat that is held back keeps its contents.
  `MPDR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(route) && $stable(hops_out) && $stable(drop_cause) && $stable(joined), "output beat changed while stalled")

  // A routed packet never carries a drop cause.
  `MPDR_ASSERT_NOW(a_routed_no_cause, clk, rst, out_valid && route != ROUTE_DROP, drop_cause == CAUSE_NONE, "routed packet with a drop cause")

  // Before joining only own-packet and not-joined drops can appear.
  `MPDR_ASSERT_NOW(a_unjoined_drop, clk, rst, out_valid && !joined, route == ROUTE_DROP && (drop_cause == CAUSE_OWN || drop_cause == CAUSE_NOT_JOINED), "unexpected result before joining")

  // A not-joined drop is only reported while the node is still out.
  `MPDR_ASSERT_NOW(a_not_joined_flag, clk, rst, out_valid && drop_cause == CAUSE_NOT_JOINED, !joined, "not-joined drop with joined flag set")

endmodule

bind mesh_packet_dedup_router mpdr_checker u_checker (.*);

// ----- tb/sv/mesh_packet_dedup_router_checker.sv -----
`timescale 1ns / 1ps
module mesh_packet_dedup_router_checker
  import mpdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [ADDR_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [ADDR_W-1:0]   source_node,
  input  logic [SEQ_W-1:0]    sequence_req,
  input  logic [KIND_W-1:0]   message_kind,
  input  logic [HOP_W-1:0]    hop_count,
  input  logic [CMD_W-1:0]    command_id,
  input  logic [ADDR_W-1:0]   command_target,
  input  logic [ADDR_W-1:0]   handshake_target,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [CODE_W-1:0]   route,
  input  logic [HOP_W-1:0]    hops_out,
  input  logic [CODE_W-1:0]   drop_cause,
  input  logic                joined,
  output int                  fail_count,
  output int                  pending_count,
  output int                  checked_count,
  output int                  action_count,
  output int                  stale_count
);

  // Routing decision for one packet header, as the block should answer it.
  typedef struct packed {
    route_t            route;
    logic [HOP_W-1:0]  hops;
    cause_t            cause;
    logic              joined;
  } verdict_t;

  // Mirror of the router's own state.
  logic [ADDR_W-1:0] node_addr;
  logic              net_joined;
  logic [15:0]       top_cmd_id;
  logic              src_known [NODE_COUNT];
  logic [SEQ_W-1:0]  src_last_seq [NODE_COUNT];

  verdict_t verdicts_due [$];
  int mismatches = 0;
  int results_seen = 0;
  int actions = 0;
  int stale_drops = 0;

  // Works out where a header goes and updates the mirrored state to match.
  function automatic verdict_t route_header(
    input logic [ADDR_W-1:0] src,
    input logic [SEQ_W-1:0]  seq,
    input kind_t             kind,
    input logic [HOP_W-1:0]  hops,
    input logic [CMD_W-1:0]  cmd_id,
    input logic [ADDR_W-1:0] cmd_tgt,
    input logic [ADDR_W-1:0] hs_tgt
  );
    verdict_t v;
    int slot;
    v.route = ROUTE_DROP;
    v.cause = CAUSE_NONE;
    v.hops  = hops;
    slot    = int'(src) % NODE_COUNT;
    if (src == node_addr) begin
      v.cause = CAUSE_OWN;
    end else if (!net_joined) begin
      // Only an ack naming this node lets it into the network.
      if (kind == KIND_HANDSHAKE_ACK && hs_tgt == node_addr) begin
        net_joined = 1'b1;
      end else begin
        v.cause = CAUSE_NOT_JOINED;
      end
    end else if (src_known[slot] && !(seq > src_last_seq[slot])) begin
      v.cause = CAUSE_STALE;
    end else begin
      src_known[slot]    = 1'b1;
      src_last_seq[slot] = seq;
      case (kind)
        KIND_COMMAND: begin
          if (top_cmd_id < {8'd0, cmd_id} && cmd_tgt == node_addr) begin
            top_cmd_id = {8'd0, cmd_id};
            v.route    = ROUTE_ACTION;
          end else begin
            v.route = ROUTE_CMD_FWD;
            v.hops  = hops + 8'd1;
          end
        end
        KIND_COMMAND_ACK: begin
          v.route = ROUTE_CMD_FWD;
          v.hops  = hops + 8'd1;
        end
        KIND_DATA: begin
          v.route = ROUTE_DATA_FWD;
          v.hops  = hops + 8'd1;
        end
        KIND_HANDSHAKE: begin
          if (hs_tgt == node_addr) begin
            v.route = ROUTE_HAND_RX;
          end else begin
            v.route = ROUTE_DATA_FWD;
            v.hops  = hops + 8'd1;
          end
        end
        default: begin
          v.cause = CAUSE_UNHANDLED;
        end
      endcase
    end
    v.joined = net_joined;
    return v;
  endfunction

  // Compares one result beat with the routing decision it should carry.
  task automatic check_result(input verdict_t want);
    if (route !== want.route) begin
      mismatches++;
      $error("route: expected %0d, got %0d", want.route, route);
    end
    if (hops_out !== want.hops) begin
      mismatches++;
      $error("hops_out: expected %0d, got %0d", want.hops, hops_out);
    end
    if (drop_cause !== want.cause) begin
      mismatches++;
      $error("drop_cause: expected %0d, got %0d", want.cause, drop_cause);
    end
    if (joined !== want.joined) begin
      mismatches++;
      $error("joined: expected %0d, got %0d", want.joined, joined);
    end
    if (want.route == ROUTE_ACTION) actions++;
    if (want.cause == CAUSE_STALE) stale_drops++;
  endtask

  // Both channels and the register port are sampled on the rising edge.
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst) begin
      node_addr  = OWN_ADDR_RESET;
      net_joined = 1'b0;
      top_cmd_id = '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        src_known[i] = 1'b0;
      end
      verdicts_due.delete();
    end else begin
      if (cfg_wr_en) node_addr = cfg_wr_data;
      if (in_valid && in_ready) begin
        verdicts_due.push_back(route_header(source_node, sequence_req, kind_t'(message_kind),
                                            hop_count, command_id, command_target,
                                            handshake_target));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $error("result beat with no packet outstanding: route %0d, drop_cause %0d",
                 route, drop_cause);
        end else begin
          want = verdicts_due.pop_front();
          check_result(want);
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= verdicts_due.size();
    checked_count <= results_seen;
    action_count  <= actions;
    stale_count   <= stale_drops;
  end

endmodule

// ----- tb/sv/mesh_packet_dedup_router_tb.sv -----
`timescale 1ns / 1ps
module mesh_packet_dedup_router_tb;
  import mpdr_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int MAX_GAP       = 11;
  localparam int PHASE_PACKETS = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 500;
  localparam int POOL_BASE     = 16;
  localparam int POOL_SIZE     = 16;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0]   cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ADDR_W-1:0]   source_node = '0;
  logic [SEQ_W-1:0]    sequence_req = '0;
  logic [KIND_W-1:0]   message_kind = '0;
  logic [HOP_W-1:0]    hop_count = '0;
  logic [CMD_W-1:0]    command_id = '0;
  logic [ADDR_W-1:0]   command_target = '0;
  logic [ADDR_W-1:0]   handshake_target = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CODE_W-1:0]   route;
  logic [HOP_W-1:0]    hops_out;
  logic [CODE_W-1:0]   drop_cause;
  logic                joined;

  int fail_count;
  int pending_count;
  int checked_count;
  int action_count;
  int stale_count;

  // Stimulus bookkeeping: the address in force, the last sequence number used
  // per source and the next command id meant to be fresh.
  logic [ADDR_W-1:0] own_addr = OWN_ADDR_RESET;
  int unsigned       seq_mark [256];
  int                cmd_next = 2;
  int                packets_sent = 0;
  bit                send_fast = 1'b0;
  bit                take_fast = 1'b0;
  int                idle_cycles = 0;
  logic [ADDR_W-1:0] phase_addr [4];

  always #HALF_PERIOD clk = ~clk;

  mesh_packet_dedup_router u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .source_node      (source_node),
    .sequence_req     (sequence_req),
    .message_kind     (message_kind),
    .hop_count        (hop_count),
    .command_id       (command_id),
    .command_target   (command_target),
    .handshake_target (handshake_target),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .route            (route),
    .hops_out         (hops_out),
    .drop_cause       (drop_cause),
    .joined           (joined)
  );

  mesh_packet_dedup_router_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .source_node      (source_node),
    .sequence_req     (sequence_req),
    .message_kind     (message_kind),
    .hop_count        (hop_count),
    .command_id       (command_id),
    .command_target   (command_target),
    .handshake_target (handshake_target),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .route            (route),
    .hops_out         (hops_out),
    .drop_cause       (drop_cause),
    .joined           (joined),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .action_count     (action_count),
    .stale_count      (stale_count)
  );

  // Presents one header beat after a random gap and holds it until accepted.
  // Called and left on a falling edge.
  task automatic send_header(
    input logic [ADDR_W-1:0] src,
    input logic [SEQ_W-1:0]  seq,
    input kind_t             kind,
    input logic [HOP_W-1:0]  hops,
    input logic [CMD_W-1:0]  cmd_id,
    input logic [ADDR_W-1:0] cmd_tgt,
    input logic [ADDR_W-1:0] hs_tgt
  );
    int gap;
    if ($urandom_range(0, 49) == 0) send_fast = !send_fast;
    gap = send_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    source_node      <= src;
    sequence_req     <= seq;
    message_kind     <= kind;
    hop_count        <= hops;
    command_id       <= cmd_id;
    command_target   <= cmd_tgt;
    handshake_target <= hs_tgt;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    packets_sent++;
  endtask

  // Mostly rising sequences from a small set of neighbours, with repeats,
  // out-of-order numbers, own-address packets and unknown sources mixed in.
  task automatic send_random_header();
    int               pick;
    int unsigned      seq;
    logic [ADDR_W-1:0] src;
    kind_t            kind;
    logic [CMD_W-1:0] cmd_id;
    logic [ADDR_W-1:0] cmd_tgt;
    logic [ADDR_W-1:0] hs_tgt;
    logic [HOP_W-1:0] hops;

    pick = $urandom_range(0, 15);
    if (pick == 0) src = own_addr;
    else if (pick < 5) src = ADDR_W'($urandom_range(0, 255));
    else src = ADDR_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));

    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      seq = seq_mark[src] + $urandom_range(1, 4);
      if (seq > 65535) seq = 65535;
    end else if (pick < 17) begin
      seq = $urandom_range(0, seq_mark[src]);
    end else begin
      seq = $urandom_range(0, 65535);
    end
    if (seq > seq_mark[src]) seq_mark[src] = seq;

    case ($urandom_range(0, 15))
      0, 1, 2, 3: kind = KIND_COMMAND;
      4, 5, 6:    kind = KIND_DATA;
      7, 8, 9:    kind = KIND_HANDSHAKE;
      10, 11:     kind = KIND_COMMAND_ACK;
      12:         kind = KIND_HANDSHAKE_ACK;
      13:         kind = KIND_NONE;
      14:         kind = KIND_GATEWAY;
      default:    kind = KIND_OTHER;
    endcase

    cmd_tgt = $urandom_range(0, 1) ? own_addr : ADDR_W'($urandom_range(0, 255));
    hs_tgt  = $urandom_range(0, 1) ? own_addr : ADDR_W'($urandom_range(0, 255));
    hops    = ($urandom_range(0, 7) == 0) ? 8'hFF : HOP_W'($urandom_range(0, 255));

    // Commands for this node climb slowly so that fresh ids keep turning up.
    if (kind == KIND_COMMAND && cmd_tgt == own_addr) begin
      if ($urandom_range(0, 3) != 0) begin
        if (cmd_next < 255 && $urandom_range(0, 1) == 1) cmd_next++;
        cmd_id = CMD_W'(cmd_next);
      end else begin
        cmd_id = CMD_W'($urandom_range(0, cmd_next));
      end
    end else begin
      cmd_id = CMD_W'($urandom_range(0, 255));
    end

    send_header(src, SEQ_W'(seq), kind, hops, cmd_id, cmd_tgt, hs_tgt);
  endtask

  // The address register is only written once the router has gone quiet.
  task automatic set_own_address(input logic [ADDR_W-1:0] addr);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    own_addr = addr;
  endtask

  // Result side: a random stall before each beat, with runs of no stalling.
  initial begin : result_sink
    int stall;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) take_fast = !take_fast;
      stall = take_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Before joining: own packets, not-joined drops and refused acks, then the joining ack.
    send_header(8'd3,   16'd0,     KIND_DATA,          8'd10,  8'd0,   8'd0,   8'd0);
    send_header(8'd7,   16'd1,     KIND_COMMAND,       8'd0,   8'd1,   8'd3,   8'd3);
    send_header(8'd7,   16'd2,     KIND_HANDSHAKE_ACK, 8'd0,   8'd0,   8'd0,   8'd9);
    send_header(8'd3,   16'd3,     KIND_HANDSHAKE_ACK, 8'd0,   8'd0,   8'd0,   8'd3);
    send_header(8'd7,   16'd0,     KIND_NONE,          8'd0,   8'd0,   8'd0,   8'd0);
    send_header(8'd7,   16'd5,     KIND_HANDSHAKE_ACK, 8'd4,   8'd0,   8'd0,   8'd3);
    // Joined: the ack left the table alone, so the same sequence is fresh.
    send_header(8'd7,   16'd5,     KIND_DATA,          8'd0,   8'd0,   8'd0,   8'd0);
    send_header(8'd7,   16'd5,     KIND_DATA,          8'd1,   8'd0,   8'd0,   8'd0);
    send_header(8'd7,   16'd4,     KIND_DATA,          8'd1,   8'd0,   8'd0,   8'd0);
    send_header(8'd7,   16'hFFFF,  KIND_COMMAND,       8'd2,   8'd1,   8'd3,   8'd0);
    send_header(8'd0,   16'd0,     KIND_COMMAND,       8'd2,   8'd1,   8'd3,   8'd0);
    send_header(8'd255, 16'hFFFF,  KIND_COMMAND,       8'hFF,  8'hFF,  8'd200, 8'hFF);
    send_header(8'd0,   16'd1,     KIND_COMMAND_ACK,   8'hFF,  8'd0,   8'd0,   8'd0);
    send_header(8'd0,   16'd2,     KIND_HANDSHAKE,     8'd9,   8'd0,   8'd0,   8'd3);
    send_header(8'd0,   16'd3,     KIND_HANDSHAKE,     8'd9,   8'd0,   8'd0,   8'hFF);
    send_header(8'd0,   16'd4,     KIND_NONE,          8'd5,   8'd0,   8'd0,   8'd0);
    send_header(8'd0,   16'd5,     KIND_HANDSHAKE_ACK, 8'd5,   8'd0,   8'd0,   8'd3);
    send_header(8'd0,   16'd6,     KIND_GATEWAY,       8'd5,   8'd0,   8'd0,   8'd0);
    send_header(8'd0,   16'd7,     KIND_OTHER,         8'd5,   8'd0,   8'd0,   8'd0);
    send_header(8'd1,   16'd100,   KIND_COMMAND,       8'd6,   8'd2,   8'd3,   8'd0);
    send_header(8'd1,   16'd101,   KIND_COMMAND,       8'd6,   8'd2,   8'd3,   8'd0);
    send_header(8'd7,   16'hFFFF,  KIND_DATA,          8'd6,   8'd0,   8'd0,   8'd0);
    send_header(8'd3,   16'd200,   KIND_DATA,          8'd6,   8'd0,   8'd0,   8'd0);

    // Random traffic under the reset address and then four written ones.
    phase_addr[0] = 8'h00;
    phase_addr[1] = 8'hFF;
    phase_addr[2] = ADDR_W'($urandom_range(1, 254));
    phase_addr[3] = OWN_ADDR_RESET;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) set_own_address(phase_addr[phase - 1]);
      repeat (PHASE_PACKETS) send_random_header();
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packet headers under five node addresses; %0d results checked.",
             packets_sent, checked_count);
    $display("%0d commands reached the action queue and %0d repeats were dropped as stale.",
             action_count, stale_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mpdr_pkg.sv
hdl/mpdr_front.sv
hdl/mpdr_queue.sv
hdl/mpdr_back.sv
hdl/mesh_packet_dedup_router.sv
hdl/mpdr_checker.sv
tb/sv/mesh_packet_dedup_router_checker.sv
tb/sv/mesh_packet_dedup_router_tb.sv
